/* src/assert_macros.svh */
// Assertion macros used by the checker file biou_check.sv.
// No dependencies; clock and active-low reset are passed in or taken as clk_i / rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on clk_i / rst_ni.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* src/biou_pkg.sv */
// Shared constants for the box overlap ratio unit.
// No dependencies; used by the interfaces, the top level and the checker.
package biou_pkg;

  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned FracBitsDef  = 16;

endpackage

/* src/biou_in_if.sv */
// Input channel: valid/ready handshake carrying one pair of boxes.
// Depends on biou_pkg for the default coordinate width.
interface biou_in_if #(
  parameter int unsigned COORD_BITS = biou_pkg::CoordBitsDef
) ();

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] a_left;
  logic [COORD_BITS-1:0] a_top;
  logic signed [COORD_BITS:0] a_width;
  logic signed [COORD_BITS:0] a_height;
  logic [COORD_BITS-1:0] b_left;
  logic [COORD_BITS-1:0] b_top;
  logic signed [COORD_BITS:0] b_width;
  logic signed [COORD_BITS:0] b_height;

  modport source (
    output valid, a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height,
    input  ready
  );

  modport sink (
    input  valid, a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height,
    output ready
  );

endinterface

/* src/biou_out_if.sv */
// Output channel: valid/ready handshake carrying one overlap ratio result.
// Depends on biou_pkg for the default fraction width.
interface biou_out_if #(
  parameter int unsigned FRAC_BITS = biou_pkg::FracBitsDef
) ();

  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] ratio;
  logic               bad_size;
  logic               overlaps;

  modport source (
    output valid, ratio, bad_size, overlaps,
    input  ready
  );

  modport sink (
    input  valid, ratio, bad_size, overlaps,
    output ready
  );

endinterface

/* src/box_iou_ratio_unit.sv */
// Top level of the box overlap ratio unit: pipelined intersection-over-union.
// Depends on biou_pkg, biou_in_if and biou_out_if.
//
// Takes one pair of boxes per cycle unless the output stalls and returns intersection
// area over union area with FRAC_BITS fraction bits, truncated.
// Four front stages form the corners, the extents, the areas and the union; then a
// restoring divider with one register stage per quotient bit (FRAC_BITS + 1 stages)
// forms the quotient, so sustained throughput is one transfer per cycle. The whole
// pipeline holds while a finished result waits and the output is not taken; empty
// stages are filled as it runs. A non-positive extent returns zero with bad_size set,
// disjoint boxes return zero with overlaps clear. No clearing pass after reset.
module box_iou_ratio_unit #(
  parameter int unsigned COORD_BITS = biou_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = biou_pkg::FracBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  biou_in_if.sink    in_i,
  biou_out_if.source out_o
);

  localparam int unsigned AreaW     = 2 * COORD_BITS;
  localparam int unsigned UniW      = AreaW + 1;
  localparam int unsigned TrialW    = UniW + 1;
  localparam int unsigned QuoW      = FRAC_BITS + 1;
  localparam int unsigned DivStages = FRAC_BITS + 1;
  localparam int unsigned NumStages = DivStages + 4;

  logic                 advance;
  logic [NumStages-1:0] vld_q, vld_d;

  // Stage 1: extents check, inclusive end corners, intersection corners.
  logic                  bad1_q;
  logic [COORD_BITS-1:0] lx1_q, ly1_q;
  logic [COORD_BITS:0]   rx1_q, ry1_q;
  logic [COORD_BITS-1:0] aw1_q, ah1_q, bw1_q, bh1_q;

  logic                  bad1_d;
  logic [COORD_BITS-1:0] lx1_d, ly1_d;
  logic [COORD_BITS:0]   rx1_d, ry1_d;
  logic [COORD_BITS:0]   a_right, a_bottom, b_right, b_bottom;

  // Stage 2: overlap extents and box areas.
  logic                  bad2_q, ovl2_q;
  logic [COORD_BITS-1:0] dw2_q, dh2_q;
  logic [AreaW-1:0]      area_a2_q, area_b2_q;
  logic                  ovl2_d;
  logic [COORD_BITS:0]   dw_full, dh_full;

  // Stage 3: intersection area and area sum.
  logic                  bad3_q, ovl3_q;
  logic [AreaW-1:0]      inter3_q;
  logic [UniW-1:0]       sum3_q;

  // Stage 4: union area.
  logic                  bad4_q, ovl4_q;
  logic [AreaW-1:0]      inter4_q;
  logic [UniW-1:0]       uni4_q;

  // Divider stages.
  logic [UniW-1:0] rem_q  [DivStages];
  logic [UniW-1:0] udiv_q [DivStages];
  logic [QuoW-1:0] quo_q  [DivStages];
  logic            badd_q [DivStages];
  logic            ovld_q [DivStages];

  assign advance    = ~vld_q[NumStages-1] | out_o.ready;
  assign in_i.ready = advance;
  assign vld_d      = {vld_q[NumStages-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    bad1_d = ~(~in_i.a_width[COORD_BITS]  & (|in_i.a_width[COORD_BITS-1:0])  &
               ~in_i.a_height[COORD_BITS] & (|in_i.a_height[COORD_BITS-1:0]) &
               ~in_i.b_width[COORD_BITS]  & (|in_i.b_width[COORD_BITS-1:0])  &
               ~in_i.b_height[COORD_BITS] & (|in_i.b_height[COORD_BITS-1:0]));
    a_right  = {1'b0, in_i.a_left} + {1'b0, in_i.a_width[COORD_BITS-1:0]}
               - (COORD_BITS+1)'(1);
    a_bottom = {1'b0, in_i.a_top} + {1'b0, in_i.a_height[COORD_BITS-1:0]}
               - (COORD_BITS+1)'(1);
    b_right  = {1'b0, in_i.b_left} + {1'b0, in_i.b_width[COORD_BITS-1:0]}
               - (COORD_BITS+1)'(1);
    b_bottom = {1'b0, in_i.b_top} + {1'b0, in_i.b_height[COORD_BITS-1:0]}
               - (COORD_BITS+1)'(1);
    lx1_d = (in_i.a_left >= in_i.b_left) ? in_i.a_left : in_i.b_left;
    ly1_d = (in_i.a_top  >= in_i.b_top)  ? in_i.a_top  : in_i.b_top;
    rx1_d = (a_right  <= b_right)  ? a_right  : b_right;
    ry1_d = (a_bottom <= b_bottom) ? a_bottom : b_bottom;
  end

  always_comb begin
    ovl2_d  = ({1'b0, lx1_q} <= rx1_q) & ({1'b0, ly1_q} <= ry1_q) & ~bad1_q;
    dw_full = rx1_q - {1'b0, lx1_q} + (COORD_BITS+1)'(1);
    dh_full = ry1_q - {1'b0, ly1_q} + (COORD_BITS+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      bad1_q <= bad1_d;
      lx1_q  <= lx1_d;
      ly1_q  <= ly1_d;
      rx1_q  <= rx1_d;
      ry1_q  <= ry1_d;
      aw1_q  <= in_i.a_width[COORD_BITS-1:0];
      ah1_q  <= in_i.a_height[COORD_BITS-1:0];
      bw1_q  <= in_i.b_width[COORD_BITS-1:0];
      bh1_q  <= in_i.b_height[COORD_BITS-1:0];

      bad2_q    <= bad1_q;
      ovl2_q    <= ovl2_d;
      dw2_q     <= dw_full[COORD_BITS-1:0];
      dh2_q     <= dh_full[COORD_BITS-1:0];
      area_a2_q <= AreaW'(aw1_q) * AreaW'(ah1_q);
      area_b2_q <= AreaW'(bw1_q) * AreaW'(bh1_q);

      bad3_q   <= bad2_q;
      ovl3_q   <= ovl2_q;
      inter3_q <= AreaW'(dw2_q) * AreaW'(dh2_q);
      sum3_q   <= {1'b0, area_a2_q} + {1'b0, area_b2_q};

      bad4_q   <= bad3_q;
      ovl4_q   <= ovl3_q;
      inter4_q <= inter3_q;
      uni4_q   <= sum3_q - {1'b0, inter3_q};
    end
  end

  for (genvar j = 0; j < DivStages; j++) begin : g_div
    logic [TrialW-1:0] trial;
    logic [UniW-1:0]   u_in;
    logic [QuoW-1:0]   q_in;
    logic              bad_in, ovl_in;
    logic              fits;
    logic [TrialW-1:0] diff;

    if (j == 0) begin : g_first
      assign trial  = {2'b00, inter4_q};
      assign u_in   = uni4_q;
      assign q_in   = '0;
      assign bad_in = bad4_q;
      assign ovl_in = ovl4_q;
    end else begin : g_next
      assign trial  = {rem_q[j-1], 1'b0};
      assign u_in   = udiv_q[j-1];
      assign q_in   = quo_q[j-1];
      assign bad_in = badd_q[j-1];
      assign ovl_in = ovld_q[j-1];
    end

    assign diff = trial - {1'b0, u_in};
    assign fits = trial >= {1'b0, u_in};

    always_ff @(posedge clk_i) begin
      if (advance) begin
        rem_q[j]  <= fits ? diff[UniW-1:0] : trial[UniW-1:0];
        udiv_q[j] <= u_in;
        quo_q[j]  <= {q_in[QuoW-2:0], fits};
        badd_q[j] <= bad_in;
        ovld_q[j] <= ovl_in;
      end
    end
  end

  assign out_o.valid    = vld_q[NumStages-1];
  assign out_o.ratio    = ovld_q[DivStages-1] ? quo_q[DivStages-1] : '0;
  assign out_o.bad_size = badd_q[DivStages-1];
  assign out_o.overlaps = ovld_q[DivStages-1];

endmodule

/* src/biou_check.sv */
// Port-level checker for box_iou_ratio_unit, attached by bind.
// Depends on biou_pkg and assert_macros.svh.
`include "assert_macros.svh"

module biou_check #(
  parameter int unsigned COORD_BITS = biou_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = biou_pkg::FracBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [FRAC_BITS:0]    out_ratio_i,
  input logic                  out_bad_size_i,
  input logic                  out_overlaps_i
);

  localparam logic [FRAC_BITS:0] RatioOne = (FRAC_BITS+1)'(1) << FRAC_BITS;

  `ASSERT_STD(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_ratio_i), "stalled result changed")
  `ASSERT_STD(a_ready_when_taken, out_ready_i |-> in_ready_i, "input blocked while output drains")
  `ASSERT_STD(a_zero_when_apart, out_valid_i && !out_overlaps_i |-> out_ratio_i == '0, "nonzero ratio without overlap")
  `ASSERT_STD(a_bad_excl, out_valid_i && out_bad_size_i |-> !out_overlaps_i, "bad size with overlap")
  `ASSERT_STD(a_ratio_max, out_valid_i |-> out_ratio_i <= RatioOne, "ratio above one")

endmodule

bind box_iou_ratio_unit biou_check #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_biou_check (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_ratio_i    (out_o.ratio),
  .out_bad_size_i (out_o.bad_size),
  .out_overlaps_i (out_o.overlaps)
);
